/* hdl/bvde_pkg.sv */
// shared types, constants and register map of the batch vector distance engine
package bvde_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_LENGTH_DEF    = 4096;
    localparam int ELEMENT_WIDTH_DEF = 16;

    // fixed widths of result and configuration fields
    localparam int ACC_W      = 48;
    localparam int CFG_LEN_W  = 13;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from address bit 2 (registers sit on 4-byte words)
    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_MEASURE_MODE  = 1'b1;

    // measure codes
    localparam logic MODE_SQ_L2 = 1'b0;
    localparam logic MODE_DOT   = 1'b1;

    // input opcodes carried on tuser
    localparam logic OP_QUERY_LOAD = 1'b0;
    localparam logic OP_TARGET     = 1'b1;

    // configuration register contents
    typedef struct packed {
        logic [CFG_LEN_W-1:0] vector_length;
        logic                 measure_mode;
    } cfg_t;

    // per-item control that rides along the arithmetic pipeline
    typedef struct packed {
        logic valid;
        logic clear;
        logic last;
        logic mode;
    } issue_t;

endpackage

/* hdl/bvde_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
module bvde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/bvde_cfg.sv */
// apb configuration registers: vector length and measure mode
module bvde_cfg
    import bvde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register write decode on the word index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_VECTOR_LENGTH: cfg_next.vector_length = pwdata[CFG_LEN_W-1:0];
                REG_MEASURE_MODE:  cfg_next.measure_mode  = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vector_length <= CFG_LEN_W'(1);
            cfg_reg.measure_mode  <= MODE_SQ_L2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_VECTOR_LENGTH: prdata = APB_DATA_W'(cfg_reg.vector_length);
            REG_MEASURE_MODE:  prdata = APB_DATA_W'(cfg_reg.measure_mode);
            default:           prdata = '0;
        endcase
    end

endmodule

/* hdl/bvde_mac.sv */
// multiply-accumulate pipeline: operand select, product, 48-bit sum and result register
module bvde_mac
    import bvde_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  issue_t                          issue,
    input  logic signed [ELEMENT_WIDTH-1:0] target_elem,
    input  logic        [ELEMENT_WIDTH-1:0] query_elem,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic        [ACC_W-1:0]         out_data
);

    localparam int OP_W   = ELEMENT_WIDTH + 1;
    localparam int PROD_W = 2 * OP_W;

    // stage 1: ram data lines up with these
    issue_t                          p1_reg;
    logic signed [ELEMENT_WIDTH-1:0] p1_t_reg;
    // stage 2: multiplier operands
    issue_t                          p2_reg;
    logic signed [OP_W-1:0]          p2_a_reg;
    logic signed [OP_W-1:0]          p2_b_reg;
    // stage 3: product
    issue_t                          p3_reg;
    logic signed [PROD_W-1:0]        p3_prod_reg;
    // accumulator and result register
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         acc_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic        [ACC_W-1:0]         out_data_reg;

    logic signed [ELEMENT_WIDTH-1:0] q;
    logic signed [OP_W-1:0]          diff;
    logic signed [OP_W-1:0]          op_a;
    logic signed [OP_W-1:0]          op_b;
    logic signed [ACC_W-1:0]         term;
    logic signed [ACC_W-1:0]         sum;
    logic                            emit;

    // pipeline holds only when a finished sum cannot enter a full result register
    assign emit    = p3_reg.valid && !p3_reg.clear && p3_reg.last;
    assign advance = !(emit && out_valid_reg && !out_ready);

    // operand select: difference squared or plain product
    assign q    = query_elem;
    assign diff = OP_W'(q) - OP_W'(p1_t_reg);
    always_comb
    begin
        unique case (p1_reg.mode)
            MODE_DOT:
            begin
                op_a = OP_W'(q);
                op_b = OP_W'(p1_t_reg);
            end
            default:
            begin
                op_a = diff;
                op_b = diff;
            end
        endcase
    end

    // control of the pipeline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else if (advance)
        begin
            p1_reg <= issue;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    // payload of the pipeline stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_t_reg    <= target_elem;
            p2_a_reg    <= op_a;
            p2_b_reg    <= op_b;
            p3_prod_reg <= p2_a_reg * p2_b_reg;
        end
    end

    // accumulate, wrapping at 48 bits
    assign term = ACC_W'(p3_prod_reg);
    assign sum  = acc_reg + term;

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && p3_reg.valid)
        begin
            priority if (p3_reg.clear)
            begin
                acc_next = '0;
            end
            else if (p3_reg.last)
            begin
                acc_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result data
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a finished sum blocked by a full result register keeps its product
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_valid_reg && !out_ready) |=> $stable(p3_prod_reg) && p3_reg.valid)
        else $error("blocked result product was not held");

    // a new result appears only after a last target left the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit && advance))
        else $error("result raised without a completed target");

    // a query load marker zeroes the running sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && p3_reg.valid && p3_reg.clear) |=> (acc_reg == '0))
        else $error("accumulator not cleared by query load");

endmodule

/* hdl/batch_vector_distance_engine.sv */
// Batch vector distance engine. A query vector is loaded element by element
// (tuser = 0) into a query RAM; target elements (tuser = 1) then stream in and
// each is combined with the query element at the same position, either as a
// squared difference or as a product (measure_mode), into an exact 48-bit
// Q32.16 sum. After vector_length target elements one result leaves on the
// master side. One item is taken every clock cycle; the rate is set by the
// single multiply-accumulate pipeline fed by one read port of the query RAM,
// with the query write port used by load items. A last target element reaches
// the result register through the stage 1, operand and product registers.
// Input is held off only when a finished sum finds the result register still
// full. A query load drops any target in progress. No clearing pass follows
// reset; the query must be loaded before targets are sent.
module batch_vector_distance_engine
    import bvde_pkg::*;
#(
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // element stream in
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0]   s_tdata,  // element_value
    input  logic                                 s_tuser,  // opcode
    // result stream out
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ACC_W-1:0]                     m_tdata,  // distance
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [APB_ADDR_W-1:0]                paddr,
    input  logic [APB_DATA_W-1:0]                pwdata,
    output logic [APB_DATA_W-1:0]                prdata,
    output logic                                 pready
);

    localparam int POS_W = $clog2(MAX_LENGTH);
    localparam int LEN_W = POS_W + 1;

    cfg_t                            cfg;
    issue_t                          issue;
    logic                            advance;
    logic                            accept;
    logic                            is_load;
    logic                            is_target;
    logic [LEN_W-1:0]                eff_len;
    logic [POS_W-1:0]                qpos_reg;
    logic [POS_W-1:0]                qpos_next;
    logic [POS_W-1:0]                tpos_reg;
    logic [POS_W-1:0]                tpos_next;
    logic                            qpos_last;
    logic                            tpos_last;
    logic signed [ELEMENT_WIDTH-1:0] elem;
    logic [ELEMENT_WIDTH-1:0]        query_elem;

    bvde_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective length: zero acts as one, clamp to the store depth
    always_comb
    begin
        priority if (cfg.vector_length == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(cfg.vector_length) > MAX_LENGTH)
        begin
            eff_len = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            eff_len = LEN_W'(cfg.vector_length);
        end
    end

    // transaction decode
    assign s_tready  = advance;
    assign accept    = s_tvalid && s_tready;
    assign is_load   = accept && (s_tuser == OP_QUERY_LOAD);
    assign is_target = accept && (s_tuser == OP_TARGET);
    assign elem      = s_tdata[ELEMENT_WIDTH-1:0];

    assign qpos_last = ({1'b0, qpos_reg} + LEN_W'(1)) >= eff_len;
    assign tpos_last = ({1'b0, tpos_reg} + LEN_W'(1)) >= eff_len;

    // position counters
    always_comb
    begin
        qpos_next = qpos_reg;
        tpos_next = tpos_reg;
        if (is_load)
        begin
            qpos_next = qpos_last ? '0 : qpos_reg + POS_W'(1);
            tpos_next = '0;
        end
        else if (is_target)
        begin
            tpos_next = tpos_last ? '0 : tpos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg <= '0;
            tpos_reg <= '0;
        end
        else
        begin
            qpos_reg <= qpos_next;
            tpos_reg <= tpos_next;
        end
    end

    // control handed to the arithmetic pipeline
    always_comb
    begin
        issue.valid = accept;
        issue.clear = is_load;
        issue.last  = tpos_last;
        issue.mode  = cfg.measure_mode;
    end

    // query store
    bvde_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (MAX_LENGTH)
    ) u_query_ram (
        .clk   (clk),
        .we    (is_load),
        .waddr (qpos_reg),
        .wdata (elem),
        .re    (is_target),
        .raddr (tpos_reg),
        .rdata (query_elem)
    );

    bvde_mac #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .target_elem (elem),
        .query_elem  (query_elem),
        .advance     (advance),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

    // one item per cycle uses at most one ram port
    assert property (@(posedge clk) disable iff (!rst_n)
        !(is_load && is_target))
        else $error("query write and target read in the same cycle");

    // a query load restarts the target position
    assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> (tpos_reg == '0))
        else $error("target position not cleared by query load");

    // a target that completes its vector sends the position back to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (is_target && tpos_last) |=> (tpos_reg == '0))
        else $error("target position did not wrap at vector end");

endmodule
